// ----- src/cfb_pkg.sv -----
`default_nettype none
package cfb_pkg;

  localparam int unsigned MUL_LAT    = 3;
  localparam int unsigned ADD_LAT    = 3;
  // input register, products, partial sums, final sums
  localparam int unsigned PIPE_DEPTH = 1 + MUL_LAT + ADD_LAT + ADD_LAT;
  localparam int unsigned E_DLY      = MUL_LAT + ADD_LAT;

  localparam logic [31:0] CANON_NAN = 32'h7fc0_0000;

  localparam logic [2:0] ADDR_INVERSE = 3'd0;

  typedef struct packed {
    logic        sign;
    logic [7:0]  exp;   // subnormals read with exponent one
    logic [23:0] man;   // hidden bit included
    logic        is_zero;
    logic        is_inf;
    logic        is_nan;
  } fp_cls_t;

  function automatic fp_cls_t fp_classify(logic [31:0] x);
    fp_cls_t c;
    c.sign    = x[31];
    c.exp     = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    c.man     = {(x[30:23] != 8'd0), x[22:0]};
    c.is_zero = (x[30:0] == 31'd0);
    c.is_inf  = (x[30:23] == 8'hff) && (x[22:0] == 23'd0);
    c.is_nan  = (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
    return c;
  endfunction

  // m[23] set means normal with exponent e, else subnormal; nearest even
  function automatic logic [31:0] round_pack(logic s, logic signed [10:0] e,
                                             logic [23:0] m, logic g, logic st);
    logic        rnd;
    logic [30:0] base;
    logic [30:0] mag;
    rnd  = g & (st | m[0]);
    base = m[23] ? {e[7:0] - 8'd1, 23'd0} : 31'd0;
    mag  = base + {7'd0, m} + {30'd0, rnd};
    if (m[23] && (e >= 11'sd255)) begin
      return {s, 8'hff, 23'd0};
    end
    return {s, mag};
  endfunction

endpackage
`default_nettype wire

// ----- src/cfb_fmul.sv -----
`default_nettype none
module cfb_fmul (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] y
);

  cfb_pkg::fp_cls_t ca, cb;
  logic [47:0] s1_p;
  logic [8:0]  s1_esum;
  logic        s1_sign, s1_nan, s1_inf, s1_zero;

  always_comb begin
    ca = cfb_pkg::fp_classify(a);
    cb = cfb_pkg::fp_classify(b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p    <= ca.man * cb.man;
      s1_esum <= {1'b0, ca.exp} + {1'b0, cb.exp};
      s1_sign <= ca.sign ^ cb.sign;
      s1_nan  <= ca.is_nan | cb.is_nan | (ca.is_inf & cb.is_zero) |
                 (ca.is_zero & cb.is_inf);
      s1_inf  <= ca.is_inf | cb.is_inf;
      s1_zero <= ca.is_zero | cb.is_zero;
    end
  end

  // leading one position and net shift
  logic [5:0]         lead;
  logic signed [10:0] e_c, k_c;
  logic [47:0]        s2_p;
  logic signed [10:0] s2_e, s2_k;
  logic               s2_sign, s2_nan, s2_inf, s2_zero;

  always_comb begin
    lead = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (s1_p[i]) lead = 6'(i);
    end
    e_c = $signed({2'b0, s1_esum}) - 11'sd173 + $signed({5'b0, lead});
    if (e_c >= 11'sd1) k_c = 11'sd47 - $signed({5'b0, lead});
    else               k_c = $signed({2'b0, s1_esum}) - 11'sd127;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p    <= s1_p;
      s2_e    <= e_c;
      s2_k    <= k_c;
      s2_sign <= s1_sign;
      s2_nan  <= s1_nan;
      s2_inf  <= s1_inf;
      s2_zero <= s1_zero;
    end
  end

  logic [47:0]        w;
  logic [95:0]        wr;
  logic [10:0]        rsh;
  logic [6:0]         rcap;
  logic               stk;
  logic signed [10:0] e_pk;

  always_comb begin
    rsh  = 11'(-s2_k);
    rcap = (rsh > 11'd48) ? 7'd48 : rsh[6:0];
    wr   = {s2_p, 48'd0} >> rcap;
    if (!s2_k[10]) begin
      w   = s2_p << s2_k[5:0];
      stk = 1'b0;
    end else begin
      w   = wr[95:48];
      stk = |wr[47:0];
    end
    e_pk = (s2_e >= 11'sd1) ? s2_e : 11'sd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s2_nan)       y <= cfb_pkg::CANON_NAN;
      else if (s2_inf)  y <= {s2_sign, 8'hff, 23'd0};
      else if (s2_zero) y <= {s2_sign, 31'd0};
      else              y <= cfb_pkg::round_pack(s2_sign, e_pk, w[47:24], w[23],
                                                 (|w[22:0]) | stk);
    end
  end

endmodule
`default_nettype wire

// ----- src/cfb_fadd.sv -----
`default_nettype none
module cfb_fadd (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic        sub,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] y
);

  cfb_pkg::fp_cls_t ca, cb, big, sml;
  logic [7:0]  d;
  logic [4:0]  dc;
  logic [53:0] sh;
  logic [26:0] al;

  always_comb begin
    ca = cfb_pkg::fp_classify(a);
    cb = cfb_pkg::fp_classify({b[31] ^ sub, b[30:0]});
    if ({cb.exp, cb.man} > {ca.exp, ca.man}) begin
      big = cb;
      sml = ca;
    end else begin
      big = ca;
      sml = cb;
    end
    d  = big.exp - sml.exp;
    dc = (d > 8'd27) ? 5'd27 : d[4:0];
    sh = {sml.man, 3'b0, 27'd0} >> dc;
    al = sh[53:27] | {26'd0, |sh[26:0]};
  end

  logic [26:0] s1_big, s1_al;
  logic [7:0]  s1_exp;
  logic        s1_sign, s1_esub, s1_zsign, s1_nan, s1_inf, s1_isign;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_big   <= {big.man, 3'b0};
      s1_al    <= al;
      s1_exp   <= big.exp;
      s1_sign  <= big.sign;
      s1_esub  <= ca.sign ^ cb.sign;
      s1_zsign <= ca.sign & cb.sign;
      s1_nan   <= ca.is_nan | cb.is_nan |
                  (ca.is_inf & cb.is_inf & (ca.sign ^ cb.sign));
      s1_inf   <= ca.is_inf | cb.is_inf;
      s1_isign <= ca.is_inf ? ca.sign : cb.sign;
    end
  end

  logic [27:0] sum_c;
  logic [4:0]  lead;
  logic [27:0] s2_sum;
  logic [4:0]  s2_lz;
  logic [7:0]  s2_exp;
  logic        s2_sign, s2_zsign, s2_nan, s2_inf, s2_isign;

  always_comb begin
    sum_c = s1_esub ? ({1'b0, s1_big} - {1'b0, s1_al}) : ({1'b0, s1_big} + {1'b0, s1_al});
    lead  = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (sum_c[i]) lead = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sum   <= sum_c;
      s2_lz    <= 5'd26 - lead;
      s2_exp   <= s1_exp;
      s2_sign  <= s1_sign;
      s2_zsign <= s1_zsign;
      s2_nan   <= s1_nan;
      s2_inf   <= s1_inf;
      s2_isign <= s1_isign;
    end
  end

  logic [26:0]        n;
  logic [7:0]         lim;
  logic [4:0]         shl;
  logic signed [10:0] e_n;

  always_comb begin
    lim = s2_exp - 8'd1;
    shl = ({3'd0, s2_lz} > lim) ? lim[4:0] : s2_lz;
    if (s2_sum[27]) begin
      n   = s2_sum[27:1] | {26'd0, s2_sum[0]};
      e_n = $signed({3'b0, s2_exp}) + 11'sd1;
    end else begin
      // cancellation only comes with exact low bits
      n   = s2_sum[26:0] << shl;
      e_n = $signed({3'b0, s2_exp}) - $signed({6'b0, shl});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s2_nan)               y <= cfb_pkg::CANON_NAN;
      else if (s2_inf)          y <= {s2_isign, 8'hff, 23'd0};
      else if (s2_sum == 28'd0) y <= {s2_zsign, 31'd0};
      else                      y <= cfb_pkg::round_pack(s2_sign, e_n, n[26:3], n[2],
                                                         |n[1:0]);
    end
  end

endmodule
`default_nettype wire

// ----- src/complex_fft_butterfly_fp32.sv -----
`default_nettype none
// channel  direction  handshake            payload
// in       sink       in_valid/in_stall    even_*, odd_*, twiddle_* (fp32)
// out      source     out_valid/out_stall  sum_*, diff_* (fp32)
// cfg      apb        psel/penable/pwrite  inverse_mode at addresses 0 to 3
//
// one beat per cycle while the output is not stalled; out_valid rises after
// the input register, 3-stage multipliers and two 3-stage add/sub levels
// rst is synchronous and clears valid bits and inverse_mode
// a stalled output freezes the whole pipeline and raises in_stall
module complex_fft_butterfly_fp32 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] even_re,
  input  wire logic [31:0] even_im,
  input  wire logic [31:0] odd_re,
  input  wire logic [31:0] odd_im,
  input  wire logic [31:0] twiddle_re,
  input  wire logic [31:0] twiddle_im,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] sum_re,
  output logic      [31:0] sum_im,
  output logic      [31:0] diff_re,
  output logic      [31:0] diff_im,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic inverse_mode;
  logic adv;
  logic [cfb_pkg::PIPE_DEPTH-1:0] vld;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, inverse_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_mode <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      inverse_mode <= pwdata[0];
    end
  end

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[cfb_pkg::PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[cfb_pkg::PIPE_DEPTH-2:0], in_valid};
    end
  end

  logic [31:0] er, ei, orr, oi, wr, wi;

  always_ff @(posedge clk) begin
    if (adv) begin
      er  <= even_re;
      ei  <= even_im;
      orr <= odd_re;
      oi  <= odd_im;
      wr  <= twiddle_re;
      wi  <= {twiddle_im[31] ^ inverse_mode, twiddle_im[30:0]};
    end
  end

  // even sample rides along the product and partial-sum stages
  logic [31:0] er_dly [cfb_pkg::E_DLY];
  logic [31:0] ei_dly [cfb_pkg::E_DLY];

  always_ff @(posedge clk) begin
    if (adv) begin
      er_dly[0] <= er;
      ei_dly[0] <= ei;
      for (int i = 1; i < cfb_pkg::E_DLY; i++) begin
        er_dly[i] <= er_dly[i-1];
        ei_dly[i] <= ei_dly[i-1];
      end
    end
  end

  logic [31:0] m_rr, m_ii, m_ri, m_ir, pr, pi;

  cfb_fmul u_mul_rr (.clk(clk), .en(adv), .a(orr), .b(wr), .y(m_rr));
  cfb_fmul u_mul_ii (.clk(clk), .en(adv), .a(oi),  .b(wi), .y(m_ii));
  cfb_fmul u_mul_ri (.clk(clk), .en(adv), .a(orr), .b(wi), .y(m_ri));
  cfb_fmul u_mul_ir (.clk(clk), .en(adv), .a(oi),  .b(wr), .y(m_ir));

  cfb_fadd u_add_pr (.clk(clk), .en(adv), .sub(1'b1), .a(m_rr), .b(m_ii), .y(pr));
  cfb_fadd u_add_pi (.clk(clk), .en(adv), .sub(1'b0), .a(m_ri), .b(m_ir), .y(pi));

  cfb_fadd u_sum_re (.clk(clk), .en(adv), .sub(1'b0),
                     .a(er_dly[cfb_pkg::E_DLY-1]), .b(pr), .y(sum_re));
  cfb_fadd u_sum_im (.clk(clk), .en(adv), .sub(1'b0),
                     .a(ei_dly[cfb_pkg::E_DLY-1]), .b(pi), .y(sum_im));
  cfb_fadd u_dif_re (.clk(clk), .en(adv), .sub(1'b1),
                     .a(er_dly[cfb_pkg::E_DLY-1]), .b(pr), .y(diff_re));
  cfb_fadd u_dif_im (.clk(clk), .en(adv), .sub(1'b1),
                     .a(ei_dly[cfb_pkg::E_DLY-1]), .b(pi), .y(diff_im));

`ifndef SYNTH
  a_hold_vld: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(vld)) else $error("pipeline moved while stalled");
  a_nan_sre: assert property (@(posedge clk) disable iff (rst)
    out_valid && sum_re[30:23] == 8'hff && sum_re[22:0] != 23'd0
    |-> sum_re == cfb_pkg::CANON_NAN) else $error("sum_re nan not canonical");
  a_nan_sim: assert property (@(posedge clk) disable iff (rst)
    out_valid && sum_im[30:23] == 8'hff && sum_im[22:0] != 23'd0
    |-> sum_im == cfb_pkg::CANON_NAN) else $error("sum_im nan not canonical");
  a_nan_dre: assert property (@(posedge clk) disable iff (rst)
    out_valid && diff_re[30:23] == 8'hff && diff_re[22:0] != 23'd0
    |-> diff_re == cfb_pkg::CANON_NAN) else $error("diff_re nan not canonical");
  a_nan_dim: assert property (@(posedge clk) disable iff (rst)
    out_valid && diff_im[30:23] == 8'hff && diff_im[22:0] != 23'd0
    |-> diff_im == cfb_pkg::CANON_NAN) else $error("diff_im nan not canonical");
`endif

endmodule
`default_nettype wire

// ----- bench/butterfly_checker.sv -----
module butterfly_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] even_re,
  input  logic [31:0] even_im,
  input  logic [31:0] odd_re,
  input  logic [31:0] odd_im,
  input  logic [31:0] twiddle_re,
  input  logic [31:0] twiddle_im,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] sum_re,
  input  logic [31:0] sum_im,
  input  logic [31:0] diff_re,
  input  logic [31:0] diff_im,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          n_fail,
  output int          n_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] s_re;
    logic [31:0] s_im;
    logic [31:0] d_re;
    logic [31:0] d_im;
  } bfly_out_t;

  bfly_out_t expected_q[$];
  logic      conj_twiddle;

  // fp32 bit pattern to double, exact
  function automatic real to_dbl(logic [31:0] x);
    logic [7:0]  e;
    logic [22:0] f;
    real         r;
    e = x[30:23];
    f = x[22:0];
    if (e == 8'hff) return $bitstoreal({x[31], 11'h7ff, f, 29'd0});
    if (e == 8'd0) begin
      if (f == 23'd0) return $bitstoreal({x[31], 63'd0});
      r = f * $bitstoreal({1'b0, 11'(1023 - 149), 52'd0});
      return x[31] ? -r : r;
    end
    return $bitstoreal({x[31], 11'(e + 896), f, 29'd0});
  endfunction

  // double to fp32, nearest even; double rounding is harmless for one op
  function automatic logic [31:0] to_sgl(real r);
    logic [63:0] b;
    logic [63:0] m53;
    logic [63:0] kept;
    logic        g;
    logic        st;
    int          ex;
    int          sh;
    b = $realtobits(r);
    if (b[62:52] == 11'h7ff)
      return (b[51:0] != 52'd0) ? cfb_pkg::CANON_NAN : {b[63], 8'hff, 23'd0};
    if (b[62:52] == 11'd0) return {b[63], 31'd0};
    ex  = int'(b[62:52]) - 1023 + 127;
    m53 = {11'd0, 1'b1, b[51:0]};
    sh  = 29 + ((ex < 1) ? (1 - ex) : 0);
    if (sh > 54) return {b[63], 31'd0};
    kept = m53 >> sh;
    g    = m53[sh-1];
    st   = (m53 & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
    kept = kept + {63'd0, g & (st | kept[0])};
    if (ex >= 1) begin
      if (kept[24]) begin
        kept = kept >> 1;
        ex   = ex + 1;
      end
      if (ex >= 255) return {b[63], 8'hff, 23'd0};
      return {b[63], 8'(ex), kept[22:0]};
    end
    // subnormal; a carry into bit 23 lands on the smallest normal
    return {b[63], kept[30:0]};
  endfunction

  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    return to_sgl(to_dbl(a) * to_dbl(b));
  endfunction

  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    return to_sgl(to_dbl(a) + to_dbl(b));
  endfunction

  function automatic logic [31:0] fsub(logic [31:0] a, logic [31:0] b);
    return to_sgl(to_dbl(a) - to_dbl(b));
  endfunction

  function automatic bfly_out_t butterfly(logic [31:0] er, logic [31:0] ei,
                                          logic [31:0] orr, logic [31:0] oi,
                                          logic [31:0] wr, logic [31:0] wi);
    bfly_out_t   o;
    logic [31:0] pr;
    logic [31:0] pi;
    pr     = fsub(fmul(orr, wr), fmul(oi, wi));
    pi     = fadd(fmul(orr, wi), fmul(oi, wr));
    o.s_re = fadd(er, pr);
    o.s_im = fadd(ei, pi);
    o.d_re = fsub(er, pr);
    o.d_im = fsub(ei, pi);
    return o;
  endfunction

  always @(posedge clk) begin
    bfly_out_t want;
    bfly_out_t got;
    if (rst) begin
      conj_twiddle <= 1'b0;
      expected_q.delete();
      n_fail <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == cfb_pkg::ADDR_INVERSE)
        conj_twiddle <= pwdata[0];
      if (in_valid && !in_stall)
        expected_q.push_back(butterfly(even_re, even_im, odd_re, odd_im, twiddle_re,
                                       conj_twiddle ? (twiddle_im ^ 32'h8000_0000)
                                                    : twiddle_im));
      if (out_valid && !out_stall) begin
        got = {sum_re, sum_im, diff_re, diff_im};
        if (expected_q.size() == 0) begin
          if (n_fail < 10) $display("unexpected beat: %h %h %h %h", sum_re, sum_im,
                                    diff_re, diff_im);
          n_fail <= n_fail + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (n_fail < 10)
              $display("beat mismatch: exp %h %h %h %h got %h %h %h %h",
                       want.s_re, want.s_im, want.d_re, want.d_im,
                       got.s_re, got.s_im, got.d_re, got.d_im);
            n_fail <= n_fail + 1;
          end
        end
      end
    end
    n_pending <= expected_q.size();
  end
endmodule

// ----- bench/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_UNUSED  = 3'd4;
  localparam int         CYCLE_LIMIT  = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] even_re = '0, even_im = '0, odd_re = '0, odd_im = '0;
  logic [31:0] twiddle_re = '0, twiddle_im = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] sum_re, sum_im, diff_re, diff_im;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          n_fail;
  int          n_pending;
  int          cycles = 0;
  int          stall_mode = 0;

  logic [31:0] specials[16] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
    32'h7fc0_0000, 32'hffff_ffff, 32'h7f7f_ffff, 32'hff7f_ffff,
    32'h0000_0001, 32'h807f_ffff, 32'h0080_0000, 32'h3f80_0000,
    32'hbf80_0000, 32'h7fa0_0001, 32'h3f00_0000, 32'h1f80_0000
  };

  complex_fft_butterfly_fp32 uut (.*);

  butterfly_checker chk (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("complex_fft_butterfly_fp32: mismatch");
      $finish;
    end
  end

  // receiver back-pressure: quiet stretches, light and heavy stalling
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  function automatic logic [31:0] rand_fp();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3: v = specials[$urandom_range(0, 15)];
      4: v[30:23] = 8'($urandom_range(0, 2));
      5: v[30:23] = 8'($urandom_range(250, 255));
      default: v[30:23] = 8'($urandom_range(117, 137));
    endcase
    return v;
  endfunction

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_beat(logic [31:0] er, logic [31:0] ei, logic [31:0] orr,
                           logic [31:0] oi, logic [31:0] wr, logic [31:0] wi);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap >= 7) gap = (gap == 9) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    else gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    even_re    <= er;
    even_im    <= ei;
    odd_re     <= orr;
    odd_im     <= oi;
    twiddle_re <= wr;
    twiddle_im <= wi;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  task automatic run_phase(int n_random);
    for (int k = 0; k < 16; k++)
      send_beat(specials[k], specials[(k + 3) % 16], specials[(k + 6) % 16],
                specials[(k + 9) % 16], specials[(k + 12) % 16],
                specials[(k + 15) % 16]);
    for (int k = 0; k < n_random; k++)
      send_beat(rand_fp(), rand_fp(), rand_fp(), rand_fp(), rand_fp(), rand_fp());
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (n_pending == 0) break;
    end
    repeat (20) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_write(cfb_pkg::ADDR_INVERSE, 32'd0);
    run_phase(250);
    apb_write(cfb_pkg::ADDR_INVERSE, 32'd1);
    apb_write(ADDR_UNUSED, 32'hffff_fffe);
    run_phase(250);
    apb_write(cfb_pkg::ADDR_INVERSE, 32'hffff_fffe);
    run_phase(250);
    if (n_fail == 0) begin
      $display("complex_fft_butterfly_fp32: match");
    end else begin
      $display("complex_fft_butterfly_fp32: mismatch");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
src/cfb_pkg.sv
src/cfb_fmul.sv
src/cfb_fadd.sv
src/complex_fft_butterfly_fp32.sv
bench/butterfly_checker.sv
bench/tb_top.sv
